@@ design/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ design/fbcs_pkg.sv @@
// Types and constants for the frame buffer change sequencer.
package fbcs_pkg;

  localparam int unsigned CountW   = 15;
  localparam int unsigned RegW     = 16;
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [RegW-1:0] IntervalManual = 16'hffff;
  localparam logic [RegW-1:0] IntervalErase  = 16'hfffe;

  localparam logic [RegW-1:0] FbcrChange     = 16'h0003;
  localparam logic [RegW-1:0] FbcrEraseOnly  = 16'h0002;
  localparam logic [RegW-1:0] FbcrDilOdd     = 16'd12;
  localparam logic [RegW-1:0] FbcrDilEven    = 16'd8;
  localparam logic [RegW-1:0] TvmrEraseEn    = 16'd8;

  typedef enum logic [1:0] {
    KIND_DISPLAY_REQ = 2'd0,
    KIND_VBLANK_IN   = 2'd1,
    KIND_VBLANK_OUT  = 2'd2,
    KIND_INTERVAL    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    MODE_ONECYCLE = 2'd0,
    MODE_INTERVAL = 2'd1,
    MODE_MANUAL   = 2'd2,
    MODE_ERASE    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ARM_NONE     = 3'd0,
    ARM_INTERVAL = 3'd1,
    ARM_MANUAL   = 3'd2,
    ARM_ERASE    = 3'd3,
    ARM_ONECYCLE = 3'd4
  } armed_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_INTERVAL     = 3'd0,
    CFG_FBCR_BASE          = 3'd1,
    CFG_TVMR_BASE          = 3'd2,
    CFG_DOUBLE_INTERLACE   = 3'd3,
    CFG_SPRITE_INITIALIZED = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       draw_end;
    logic       odd_field;
  } item_t;

  typedef struct packed {
    logic            tvmr_write;
    logic [RegW-1:0] tvmr_value;
    logic            fbcr_write;
    logic [RegW-1:0] fbcr_value;
    logic            scroll_show;
    logic            display_busy;
  } result_t;

endpackage

@@ design/frame_buffer_change_sequencer.sv @@
// Frame buffer change sequencer: one event word in, one register-write word out.
// Latency: a result word is valid the cycle after its event word is accepted.
// Throughput: one word per cycle while result_ready stays high; the single output register is the only stage.
// An event word is taken while the output register is empty or being drained.
// Synchronous active-high reset clears all config registers, the field counter,
// the request flags, the armed change and the output valid.
module frame_buffer_change_sequencer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  fbcs_pkg::item_t               item,
  output logic                          result_valid,
  input  logic                          result_ready,
  output fbcs_pkg::result_t             result,
  input  logic                          cfg_write,
  input  logic [fbcs_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [fbcs_pkg::RegW-1:0]     cfg_data
);
  import fbcs_pkg::*;

  logic [RegW-1:0]   frame_interval;
  logic [RegW-1:0]   fbcr_base;
  logic [RegW-1:0]   tvmr_base;
  logic              double_interlace;
  logic              sprite_initialized;

  logic [CountW-1:0] field_counter, field_counter_next;
  logic              display_request, display_request_next;
  logic              draw_wait_request, draw_wait_request_next;
  armed_t            armed_change, armed_change_next;
  result_t           result_next;

  mode_t             mode;
  logic [CountW-1:0] count;
  logic [CountW-1:0] cnt_inc;
  logic              accept;

  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;
  assign count      = frame_interval[CountW-1:0];
  assign cnt_inc    = field_counter + CountW'(1);

  always_comb begin
    if (frame_interval == IntervalManual) begin
      mode = MODE_MANUAL;
    end else if (frame_interval == IntervalErase) begin
      mode = MODE_ERASE;
    end else if (count <= CountW'(1)) begin
      mode = MODE_ONECYCLE;
    end else begin
      mode = MODE_INTERVAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_interval     <= '0;
      fbcr_base          <= '0;
      tvmr_base          <= '0;
      double_interlace   <= 1'b0;
      sprite_initialized <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_FRAME_INTERVAL:     frame_interval     <= cfg_data;
        CFG_FBCR_BASE:          fbcr_base          <= cfg_data;
        CFG_TVMR_BASE:          tvmr_base          <= cfg_data;
        CFG_DOUBLE_INTERLACE:   double_interlace   <= cfg_data[0];
        CFG_SPRITE_INITIALIZED: sprite_initialized <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    field_counter_next     = field_counter;
    display_request_next   = display_request;
    draw_wait_request_next = draw_wait_request;
    armed_change_next      = armed_change;
    result_next            = '0;

    case (kind_t'(item.kind))
      KIND_DISPLAY_REQ: begin
        if (!((mode == MODE_ONECYCLE || mode == MODE_INTERVAL) && count == '0)) begin
          display_request_next = 1'b1;
        end
      end
      KIND_VBLANK_IN: begin
        case (mode)
          MODE_MANUAL: begin
            if (display_request) begin
              result_next.scroll_show = 1'b1;
              armed_change_next       = ARM_MANUAL;
            end
          end
          MODE_ERASE: begin
            if (display_request) begin
              result_next.tvmr_write  = 1'b1;
              result_next.tvmr_value  = tvmr_base | TvmrEraseEn;
              result_next.fbcr_write  = 1'b1;
              result_next.fbcr_value  = fbcr_base | FbcrChange;
              result_next.scroll_show = 1'b1;
              armed_change_next       = ARM_ERASE;
            end
          end
          MODE_ONECYCLE: begin
            result_next.scroll_show = 1'b1;
            armed_change_next       = ARM_ONECYCLE;
          end
          default: begin
            // interval mode: count is at least two here
            if (!frame_interval[RegW-1] && cnt_inc >= count - CountW'(1)) begin
              result_next.fbcr_write = 1'b1;
              result_next.fbcr_value = fbcr_base | FbcrEraseOnly;
            end
            if (cnt_inc >= count) begin
              if (display_request) begin
                result_next.scroll_show = 1'b1;
                armed_change_next       = ARM_INTERVAL;
              end
              field_counter_next = '0;
            end else begin
              field_counter_next = cnt_inc;
            end
          end
        endcase
      end
      KIND_VBLANK_OUT: begin
        if (double_interlace) begin
          result_next.fbcr_write = 1'b1;
          result_next.fbcr_value = fbcr_base | (item.odd_field ? FbcrDilOdd : FbcrDilEven);
          armed_change_next      = ARM_NONE;
          display_request_next   = 1'b0;
        end else if (armed_change != ARM_NONE) begin
          if (armed_change == ARM_MANUAL && sprite_initialized && !item.draw_end) begin
            draw_wait_request_next = 1'b1;
            display_request_next   = 1'b0;
          end else begin
            if (armed_change == ARM_ERASE) begin
              result_next.tvmr_write = 1'b1;
              result_next.tvmr_value = tvmr_base;
            end else if (armed_change == ARM_INTERVAL || armed_change == ARM_MANUAL) begin
              result_next.fbcr_write = 1'b1;
              result_next.fbcr_value = fbcr_base | FbcrChange;
            end
            armed_change_next      = ARM_NONE;
            draw_wait_request_next = 1'b0;
            display_request_next   = 1'b0;
          end
        end
      end
      default: begin
        result_next.fbcr_write = 1'b1;
        result_next.fbcr_value = (mode == MODE_ONECYCLE) ? fbcr_base : (fbcr_base | FbcrChange);
      end
    endcase

    result_next.display_busy = display_request_next || draw_wait_request_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_counter     <= '0;
      display_request   <= 1'b0;
      draw_wait_request <= 1'b0;
      armed_change      <= ARM_NONE;
      result_valid      <= 1'b0;
    end else begin
      if (accept) begin
        field_counter     <= field_counter_next;
        display_request   <= display_request_next;
        draw_wait_request <= draw_wait_request_next;
        armed_change      <= armed_change_next;
        result_valid      <= 1'b1;
      end else if (result_ready) begin
        result_valid      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

endmodule

@@ design/fbcs_checker.sv @@
// Port-level checker for the frame buffer change sequencer, bound to the top level.
`include "assert_macros.svh"

module fbcs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          item_valid,
  input logic                          item_ready,
  input logic                          result_valid,
  input logic                          result_ready,
  input fbcs_pkg::result_t             result
);
  import fbcs_pkg::*;

  // every accepted event word yields a result word next cycle
  `ASSERT_NEXT(a_accept_gives_result, clk, rst, item_valid && item_ready, result_valid)

  // single output stage: no new word while a result is stalled
  `ASSERT_IMPLY(a_stall_blocks_input, clk, rst, result_valid && !result_ready, !item_ready)

  // stalled result word holds
  `ASSERT_NEXT(a_result_holds, clk, rst, result_valid && !result_ready, $stable(result))

  // values are zero when the matching write strobe is low
  `ASSERT_IMPLY(a_tvmr_zero, clk, rst, result_valid && !result.tvmr_write, result.tvmr_value == '0)
  `ASSERT_IMPLY(a_fbcr_zero, clk, rst, result_valid && !result.fbcr_write, result.fbcr_value == '0)

endmodule

bind frame_buffer_change_sequencer fbcs_checker u_fbcs_checker (.*);

@@ tb/frame_buffer_change_sequencer_tb.sv @@
// Testbench for the frame buffer change sequencer: predicted register writes vs. result words.
`timescale 1ns / 1ps

module frame_buffer_change_sequencer_tb;
  import fbcs_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_t result;
  logic cfg_write = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [RegW-1:0] cfg_data = '0;

  frame_buffer_change_sequencer uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // shadow registers and sequencer state
  logic [RegW-1:0] intv_reg = '0;
  logic [RegW-1:0] fbcr_reg = '0;
  logic [RegW-1:0] tvmr_reg = '0;
  logic dil_on = 1'b0;
  logic spr_init = 1'b0;
  logic [CountW-1:0] fcnt = '0;
  logic disp_req = 1'b0;
  logic draw_wait = 1'b0;
  armed_t armed = ARM_NONE;

  item_t pending_events[$];
  result_t expected_writes[$];
  result_t want_w;
  int errors = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  function automatic result_t predict_event(item_t ev);
    mode_t m;
    logic [CountW-1:0] cnt;
    logic [CountW-1:0] nxt;
    result_t r;
    r = '0;
    cnt = intv_reg[CountW-1:0];
    if (intv_reg == IntervalManual) m = MODE_MANUAL;
    else if (intv_reg == IntervalErase) m = MODE_ERASE;
    else if (cnt <= 1) m = MODE_ONECYCLE;
    else m = MODE_INTERVAL;
    case (kind_t'(ev.kind))
      KIND_DISPLAY_REQ: begin
        if (!((m == MODE_ONECYCLE || m == MODE_INTERVAL) && cnt == 0)) disp_req = 1'b1;
      end
      KIND_VBLANK_IN: begin
        case (m)
          MODE_MANUAL: begin
            if (disp_req) begin
              r.scroll_show = 1'b1;
              armed = ARM_MANUAL;
            end
          end
          MODE_ERASE: begin
            if (disp_req) begin
              r.tvmr_write = 1'b1;
              r.tvmr_value = tvmr_reg | TvmrEraseEn;
              r.fbcr_write = 1'b1;
              r.fbcr_value = fbcr_reg | FbcrChange;
              r.scroll_show = 1'b1;
              armed = ARM_ERASE;
            end
          end
          MODE_ONECYCLE: begin
            r.scroll_show = 1'b1;
            armed = ARM_ONECYCLE;
          end
          default: begin
            nxt = fcnt + 1'b1;
            if (!intv_reg[RegW-1] && nxt >= cnt - 1'b1) begin
              r.fbcr_write = 1'b1;
              r.fbcr_value = fbcr_reg | FbcrEraseOnly;
            end
            if (nxt >= cnt) begin
              if (disp_req) begin
                r.scroll_show = 1'b1;
                armed = ARM_INTERVAL;
              end
              nxt = '0;
            end
            fcnt = nxt;
          end
        endcase
      end
      KIND_VBLANK_OUT: begin
        if (dil_on) begin
          r.fbcr_write = 1'b1;
          r.fbcr_value = fbcr_reg | (ev.odd_field ? FbcrDilOdd : FbcrDilEven);
          armed = ARM_NONE;
          disp_req = 1'b0;
        end else if (armed != ARM_NONE) begin
          if (armed == ARM_MANUAL && spr_init && !ev.draw_end) begin
            draw_wait = 1'b1;
            disp_req = 1'b0;
          end else begin
            if (armed == ARM_ERASE) begin
              r.tvmr_write = 1'b1;
              r.tvmr_value = tvmr_reg;
            end else if (armed == ARM_INTERVAL || armed == ARM_MANUAL) begin
              r.fbcr_write = 1'b1;
              r.fbcr_value = fbcr_reg | FbcrChange;
            end
            armed = ARM_NONE;
            draw_wait = 1'b0;
            disp_req = 1'b0;
          end
        end
      end
      default: begin
        r.fbcr_write = 1'b1;
        r.fbcr_value = (m == MODE_ONECYCLE) ? fbcr_reg : (fbcr_reg | FbcrChange);
      end
    endcase
    r.display_busy = disp_req | draw_wait;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) expected_writes.push_back(predict_event(item));
      if (!item_valid || item_ready) begin
        if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          item_valid <= 1'b1;
          item <= pending_events.pop_front();
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [RegW-1:0] want,
                             input logic [RegW-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  // monitor
  always @(posedge clk) begin
    result_ready <= ($urandom_range(99) >= stall_pct);
    if (!rst && result_valid && result_ready) begin
      if (expected_writes.size() == 0) begin
        $error("result word with no event outstanding");
        errors++;
      end else begin
        want_w = expected_writes.pop_front();
        check_field("tvmr_write", RegW'(want_w.tvmr_write), RegW'(result.tvmr_write));
        check_field("tvmr_value", want_w.tvmr_value, result.tvmr_value);
        check_field("fbcr_write", RegW'(want_w.fbcr_write), RegW'(result.fbcr_write));
        check_field("fbcr_value", want_w.fbcr_value, result.fbcr_value);
        check_field("scroll_show", RegW'(want_w.scroll_show), RegW'(result.scroll_show));
        check_field("display_busy", RegW'(want_w.display_busy), RegW'(result.display_busy));
      end
    end
  end

  task automatic queue_event(input kind_t k, input logic de, input logic odd);
    item_t ev;
    ev.kind = k;
    ev.draw_end = de;
    ev.odd_field = odd;
    pending_events.push_back(ev);
  endtask

  task automatic apply_reg(input cfg_idx_t idx, input logic [RegW-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_FRAME_INTERVAL: intv_reg = val;
      CFG_FBCR_BASE: fbcr_reg = val;
      CFG_TVMR_BASE: tvmr_reg = val;
      CFG_DOUBLE_INTERLACE: dil_on = val[0];
      CFG_SPRITE_INITIALIZED: spr_init = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_events.size() != 0 || item_valid || expected_writes.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  // mostly complete fields with random content, some noise words
  task automatic gen_fields(input int n);
    int start;
    start = pending_events.size();
    while (pending_events.size() - start < n) begin
      if ($urandom_range(9) != 0) begin
        if ($urandom_range(9) == 0) queue_event(KIND_INTERVAL, 1'($urandom), 1'($urandom));
        if ($urandom_range(3) != 0) queue_event(KIND_DISPLAY_REQ, 1'($urandom), 1'($urandom));
        queue_event(KIND_VBLANK_IN, 1'($urandom), 1'($urandom));
        if ($urandom_range(9) == 0) queue_event(KIND_DISPLAY_REQ, 1'($urandom), 1'($urandom));
        queue_event(KIND_VBLANK_OUT, $urandom_range(3) != 0, 1'($urandom));
      end else begin
        queue_event(kind_t'($urandom_range(3)), 1'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    logic [RegW-1:0] iv;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: one-cycle mode, zero count
    queue_event(KIND_DISPLAY_REQ, 1'b0, 1'b0);
    queue_event(KIND_VBLANK_IN, 1'b0, 1'b0);
    queue_event(KIND_VBLANK_OUT, 1'b1, 1'b1);
    queue_event(KIND_INTERVAL, 1'b0, 1'b0);
    wait_idle();

    // manual swap, drawing not finished then finished
    apply_reg(CFG_FRAME_INTERVAL, IntervalManual);
    apply_reg(CFG_SPRITE_INITIALIZED, 16'd1);
    apply_reg(CFG_FBCR_BASE, 16'ha5a4);
    apply_reg(CFG_TVMR_BASE, 16'h5a50);
    queue_event(KIND_DISPLAY_REQ, 1'b0, 1'b0);
    queue_event(KIND_VBLANK_IN, 1'b0, 1'b0);
    queue_event(KIND_VBLANK_OUT, 1'b0, 1'b0);
    queue_event(KIND_VBLANK_OUT, 1'b1, 1'b0);
    wait_idle();

    // erase-enable mode
    apply_reg(CFG_FRAME_INTERVAL, IntervalErase);
    queue_event(KIND_DISPLAY_REQ, 1'b0, 1'b0);
    queue_event(KIND_VBLANK_IN, 1'b0, 1'b0);
    queue_event(KIND_VBLANK_OUT, 1'b1, 1'b0);
    queue_event(KIND_INTERVAL, 1'b0, 1'b0);
    wait_idle();

    // swap every two fields with erase pulse
    apply_reg(CFG_FRAME_INTERVAL, 16'd2);
    queue_event(KIND_DISPLAY_REQ, 1'b0, 1'b0);
    queue_event(KIND_VBLANK_IN, 1'b0, 1'b0);
    queue_event(KIND_VBLANK_IN, 1'b0, 1'b0);
    queue_event(KIND_VBLANK_OUT, 1'b1, 1'b0);
    wait_idle();

    // double interlace
    apply_reg(CFG_DOUBLE_INTERLACE, 16'd1);
    apply_reg(CFG_FBCR_BASE, 16'hffff);
    apply_reg(CFG_TVMR_BASE, 16'hffff);
    queue_event(KIND_DISPLAY_REQ, 1'b0, 1'b0);
    queue_event(KIND_VBLANK_OUT, 1'b0, 1'b1);
    queue_event(KIND_VBLANK_OUT, 1'b0, 1'b0);
    wait_idle();

    // count lowered below the running field counter
    apply_reg(CFG_DOUBLE_INTERLACE, 16'd0);
    apply_reg(CFG_FBCR_BASE, 16'h0000);
    apply_reg(CFG_TVMR_BASE, 16'h0000);
    apply_reg(CFG_FRAME_INTERVAL, 16'd6);
    repeat (4) queue_event(KIND_VBLANK_IN, 1'b0, 1'b0);
    wait_idle();
    apply_reg(CFG_FRAME_INTERVAL, 16'd2);
    queue_event(KIND_VBLANK_IN, 1'b0, 1'b0);
    wait_idle();

    for (int p = 0; p < 12; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 67; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 67; end
        default: begin send_idle_pct = 19; stall_pct = 19; end
      endcase
      case ($urandom_range(9))
        0: iv = IntervalManual;
        1: iv = IntervalErase;
        2: iv = {$urandom_range(1) != 0, 14'd0, $urandom_range(1) != 0};
        3, 4, 5, 6: iv = {$urandom_range(1) != 0, 15'($urandom_range(2, 6))};
        7: iv = {$urandom_range(1) != 0, 15'($urandom_range(7, 40))};
        8: iv = RegW'($urandom);
        default: iv = ($urandom_range(1) != 0) ? 16'h7fff : 16'h8000;
      endcase
      apply_reg(CFG_FRAME_INTERVAL, iv);
      if ($urandom_range(1) != 0) begin
        case ($urandom_range(2))
          0: apply_reg(CFG_FBCR_BASE, 16'h0000);
          1: apply_reg(CFG_FBCR_BASE, 16'hffff);
          default: apply_reg(CFG_FBCR_BASE, RegW'($urandom));
        endcase
      end
      if ($urandom_range(1) != 0) begin
        case ($urandom_range(2))
          0: apply_reg(CFG_TVMR_BASE, 16'h0000);
          1: apply_reg(CFG_TVMR_BASE, 16'hffff);
          default: apply_reg(CFG_TVMR_BASE, RegW'($urandom));
        endcase
      end
      if ($urandom_range(1) != 0) begin
        apply_reg(CFG_DOUBLE_INTERLACE, RegW'($urandom_range(3) == 0));
      end
      if ($urandom_range(1) != 0) begin
        apply_reg(CFG_SPRITE_INITIALIZED, RegW'($urandom_range(1)));
      end
      gen_fields(60);
      // sender holds off until every result is back
      wait_idle();
      gen_fields(65);
      wait_idle();
    end

    repeat (4) @(posedge clk);
    if (expected_writes.size() != 0) begin
      $error("%0d result words never arrived", expected_writes.size());
      errors++;
    end
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
